[rtl/brapq_pkg.sv]
package brapq_pkg;

    // Field widths of the stream words
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam int VAL_W = 64;

    // Input word: left_index, right_index, add_value from bit 0 up
    localparam int S_TDATA_W = 2 * IDX_W + VAL_W;

    // Default geometry
    localparam int DEPTH_DEF      = 4096;
    localparam int BLOCK_SIZE_DEF = 64;

    // Element count after reset
    localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

    // Item kinds carried on the input tuser bit
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

[rtl/block_range_add_point_query.sv]
// Range-add / point-query store over DEPTH signed 64-bit elements in blocks of
// BLOCK_SIZE, with one 64-bit pending-add tag per block, both held in synchronous
// RAMs with one read port and one write port each. After reset the block runs a
// clearing pass (o_s_tready low) that zeroes both RAMs.
// A query is captured, reads both RAMs, then puts the sum into the output
// register once that register is free to take it.
// A rejected add (reversed or past the count) goes straight back to idle. An
// accepted add runs a setup step, then one read-modify-write through the RAM
// port per element in the partial end blocks and per interior block tag, then
// a drain step; no new word is taken until the add is through.
// Only queries return a word; index_error rides on o_m_tuser.
module block_range_add_point_query #(
    parameter int DEPTH      = brapq_pkg::DEPTH_DEF,
    parameter int BLOCK_SIZE = brapq_pkg::BLOCK_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: element_count
    input  logic                             i_cfg_wen,
    input  logic [brapq_pkg::CNT_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [11:0] left_index, [23:12] right_index, [87:24] add_value
    input  logic [brapq_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [0] mode
    input  logic                             i_s_tuser,
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [63:0] element_value
    output logic [brapq_pkg::VAL_W-1:0]      o_m_tdata,
    // [0] index_error
    output logic                             o_m_tuser
);
    import brapq_pkg::*;

    localparam int NB     = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = (NB > 1) ? $clog2(NB) : 1;
    // block number by reciprocal multiply: exact for 12-bit indices
    localparam int DIV_SH = 24;
    localparam int RCP_W  = DIV_SH - 1;
    localparam int PROD_W = IDX_W + RCP_W;
    localparam int QW     = PROD_W - DIV_SH;
    localparam int unsigned RECIP = ((1 << DIV_SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BASE, S_ELO, S_EHI, S_TAG, S_DRAIN, S_QRD, S_QOUT
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic [AW-1:0]          r_ptr;
    logic [AW-1:0]          r_end;
    logic [AW-1:0]          r_hi_start;
    logic                   r_mode;
    logic                   r_ok;
    logic [IDX_W-1:0]       r_lo;
    logic [IDX_W-1:0]       r_hi;
    logic [QW-1:0]          r_blo;
    logic [QW-1:0]          r_bhi;
    logic [VAL_W-1:0]       r_amt;
    logic                   r_pend;
    logic                   r_pend_tag;
    logic [AW-1:0]          r_waddr;
    logic [VAL_W-1:0]       r_elem_rd;
    logic [VAL_W-1:0]       r_tag_rd;
    logic                   r_out_valid;
    logic [VAL_W-1:0]       r_out_data;
    logic                   r_out_err;

    logic [VAL_W-1:0]       r_elem_mem [DEPTH];
    logic [VAL_W-1:0]       r_tag_mem  [NB];

    // Input word unpacking
    logic [IDX_W-1:0]       s_lo;
    logic [IDX_W-1:0]       s_hi;
    logic [VAL_W-1:0]       s_amt;
    logic                   s_accept;
    logic                   hi_ok;
    logic [PROD_W-1:0]      lo_prod;
    logic [PROD_W-1:0]      hi_prod;

    assign s_lo     = i_s_tdata[IDX_W-1:0];
    assign s_hi     = i_s_tdata[2*IDX_W-1:IDX_W];
    assign s_amt    = i_s_tdata[S_TDATA_W-1:2*IDX_W];
    assign s_accept = i_s_tvalid && o_s_tready;
    assign hi_ok    = ({1'b0, s_hi} < r_count) && (32'(s_hi) < 32'(DEPTH));

    // Block numbers of both ends
    assign lo_prod = PROD_W'(s_lo) * PROD_W'(RECIP);
    assign hi_prod = PROD_W'(s_hi) * PROD_W'(RECIP);

    // Block boundaries, widened then cut to the address width
    logic [31:0]            lo_end_w;
    logic [31:0]            hi_start_w;
    logic [31:0]            tag_first_w;
    logic [31:0]            tag_last_w;
    logic [31:0]            lo_w;
    logic [31:0]            hi_w;
    logic [31:0]            bhi_w;
    logic [31:0]            ptr_w;
    logic                   single_blk;
    logic                   has_inner;

    assign lo_end_w    = (32'(r_blo) + 32'd1) * 32'(BLOCK_SIZE) - 32'd1;
    assign hi_start_w  = 32'(r_bhi) * 32'(BLOCK_SIZE);
    assign tag_first_w = 32'(r_blo) + 32'd1;
    assign tag_last_w  = 32'(r_bhi) - 32'd1;
    assign lo_w        = 32'(r_lo);
    assign hi_w        = 32'(r_hi);
    assign bhi_w       = 32'(r_bhi);
    assign ptr_w       = 32'(r_ptr);
    assign single_blk  = (r_blo == r_bhi);
    assign has_inner   = ({1'b0, r_bhi} > ({1'b0, r_blo} + 1'b1));

    // RAM port control
    logic                   clearing;
    logic                   elem_re;
    logic [AW-1:0]          elem_raddr;
    logic                   elem_we;
    logic [AW-1:0]          elem_waddr;
    logic [VAL_W-1:0]       elem_wdata;
    logic                   tag_re;
    logic [TW-1:0]          tag_raddr;
    logic                   tag_we;
    logic [TW-1:0]          tag_waddr;
    logic [VAL_W-1:0]       tag_wdata;
    logic                   walk_last;
    logic                   out_free;

    assign clearing   = (r_state == S_CLEAR);
    assign elem_re    = (r_state == S_ELO) || (r_state == S_EHI) || (r_state == S_QRD);
    assign elem_raddr = (r_state == S_QRD) ? hi_w[AW-1:0] : r_ptr;
    assign tag_re     = (r_state == S_TAG) || (r_state == S_QRD);
    assign tag_raddr  = (r_state == S_QRD) ? bhi_w[TW-1:0] : ptr_w[TW-1:0];

    assign elem_we    = clearing || (r_pend && !r_pend_tag);
    assign elem_waddr = clearing ? r_ptr : r_waddr;
    assign elem_wdata = clearing ? '0 : (r_elem_rd + r_amt);
    assign tag_we     = clearing ? (ptr_w < 32'(NB)) : (r_pend && r_pend_tag);
    assign tag_waddr  = clearing ? ptr_w[TW-1:0] : r_waddr[TW-1:0];
    assign tag_wdata  = clearing ? '0 : (r_tag_rd + r_amt);

    assign walk_last  = (r_ptr == r_end);
    assign out_free   = !r_out_valid || i_m_tready;

    // Element RAM
    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            r_elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re) begin
            r_elem_rd <= r_elem_mem[elem_raddr];
        end
    end

    // Block tag RAM
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_waddr] <= tag_wdata;
        end
        if (tag_re) begin
            r_tag_rd <= r_tag_mem[tag_raddr];
        end
    end

    // Sequencer, write-back stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= CNT_RESET;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_count <= i_cfg_wdata;
            end
            // output word held until taken, reloaded by a finished query
            r_out_valid <= ((r_state == S_QOUT) && out_free) ||
                           (r_out_valid && !i_m_tready);

            // each walk step reads now and writes back next cycle
            r_pend     <= (r_state == S_ELO) || (r_state == S_EHI) || (r_state == S_TAG);
            r_waddr    <= r_ptr;
            r_pend_tag <= (r_state == S_TAG);

            case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_mode <= i_s_tuser;
                        r_lo   <= s_lo;
                        r_hi   <= s_hi;
                        r_amt  <= s_amt;
                        r_blo  <= lo_prod[PROD_W-1:DIV_SH];
                        r_bhi  <= hi_prod[PROD_W-1:DIV_SH];
                        if (i_s_tuser == MODE_QUERY) begin
                            r_ok    <= hi_ok;
                            r_state <= S_QRD;
                        end else begin
                            r_ok    <= hi_ok && (s_lo <= s_hi);
                            r_state <= (hi_ok && (s_lo <= s_hi)) ? S_BASE : S_IDLE;
                        end
                    end
                end
                S_BASE: begin
                    r_ptr      <= lo_w[AW-1:0];
                    r_end      <= single_blk ? hi_w[AW-1:0] : lo_end_w[AW-1:0];
                    r_hi_start <= hi_start_w[AW-1:0];
                    r_state    <= S_ELO;
                end
                S_ELO: begin
                    if (walk_last) begin
                        if (single_blk) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_ptr   <= r_hi_start;
                            r_end   <= hi_w[AW-1:0];
                            r_state <= S_EHI;
                        end
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_EHI: begin
                    if (walk_last) begin
                        if (has_inner) begin
                            r_ptr   <= tag_first_w[AW-1:0];
                            r_end   <= tag_last_w[AW-1:0];
                            r_state <= S_TAG;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_TAG: begin
                    if (walk_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_IDLE;
                end
                S_QRD: begin
                    r_state <= S_QOUT;
                end
                S_QOUT: begin
                    if (out_free) begin
                        r_out_data  <= r_ok ? (r_elem_rd + r_tag_rd) : '0;
                        r_out_err   <= !r_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;

    // write-back never lands on the entry being read in the same cycle
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (elem_re && elem_we && !clearing) |-> (elem_raddr != elem_waddr))
        else $error("element read and write-back hit the same entry");

    // nothing outstanding when a new word is taken
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_pend)
        else $error("new word taken with a write-back pending");

    // walk pointer stays at or below its end
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ELO) || (r_state == S_EHI) || (r_state == S_TAG))
            |-> (r_ptr <= r_end))
        else $error("walk pointer ran past its end");

    // results only come from queries
    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state == S_QOUT) && (r_mode == MODE_QUERY)))
        else $error("result word without a query");

    // an out-of-range query reports a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("error word with nonzero value");

endmodule
